FILE: design/tcw_pkg.sv
package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 50;
   localparam int CELLS   = COLUMNS * ROWS;

   localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CELL_W = 16;

   localparam logic [CELL_W-1:0] FILL_CELL = 16'h0F00;

   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_RETURN  = 8'd13;
   localparam logic [7:0] CH_TAB     = 8'd9;
   localparam logic [7:0] CH_SPACE   = 8'd32;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   localparam logic [0:0] CSR_TEXT_COLOR       = 1'b0;
   localparam logic [0:0] CSR_BACKGROUND_COLOR = 1'b1;

   localparam logic [3:0] TEXT_COLOR_RESET       = 4'd15;
   localparam logic [3:0] BACKGROUND_COLOR_RESET = 4'd0;

   typedef struct packed {
      logic        func;
      logic [7:0]  character;
      logic [11:0] read_index;
   } req_type;

   typedef struct packed {
      logic [6:0]  cursor_column;
      logic [5:0]  cursor_row;
      logic [11:0] cursor_linear;
      logic [15:0] cell_data;
      logic        did_scroll;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PUT,
      ST_SCROLL,
      ST_READ,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic put;
      logic read;
      logic sweep;
      logic clear;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic req_read;
      logic need_scroll;
      logic last_put;
      logic all_puts_done;
      logic sweep_last;
      logic rsp_free;
   } status_type;

endpackage

FILE: design/tcw_controller.sv
module tcw_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tcw_pkg::status_type status,
   output tcw_pkg::cmd_type    cmd
);
   import tcw_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            cmd.clear = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = status.req_read ? ST_READ : ST_PUT;
            end
         end
         ST_PUT: begin
            cmd.put = 1'b1;
            if (status.need_scroll) begin
               state_in = ST_SCROLL;
            end else if (status.last_put) begin
               state_in = ST_FINISH;
            end
         end
         ST_SCROLL: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = status.all_puts_done ? ST_FINISH : ST_PUT;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: design/tcw_datapath.sv
module tcw_datapath (
   input  logic                clock,
   input  logic                reset,
   input  tcw_pkg::req_type    req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tcw_pkg::rsp_type    rsp_payload,
   input  logic                csr_we,
   input  logic [0:0]          csr_index,
   input  logic [3:0]          csr_wdata,
   input  tcw_pkg::cmd_type    cmd,
   output tcw_pkg::status_type status
);
   import tcw_pkg::*;

   logic [CELL_W-1:0] cell_mem_ff [CELLS];

   logic [3:0]        text_color_ff;
   logic [3:0]        background_color_ff;
   req_type           req_ff;
   logic [COL_W-1:0]  col_ff;
   logic [COL_W-1:0]  col_in;
   logic [ROW_W-1:0]  row_ff;
   logic [ROW_W-1:0]  row_in;
   logic [1:0]        puts_ff;
   logic              all_done_ff;
   logic              scrolled_ff;
   logic [ADDR_W-1:0] sweep_ff;
   logic              oor_ff;
   logic [CELL_W-1:0] rd_ff;
   logic              wq_en_ff;
   logic              wq_en_in;
   logic              wq_copy_ff;
   logic              wq_copy_in;
   logic [ADDR_W-1:0] wq_addr_ff;
   logic [ADDR_W-1:0] wq_addr_in;
   logic [CELL_W-1:0] wq_data_ff;
   logic [CELL_W-1:0] wq_data_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;

   logic              is_tab;
   logic [7:0]        ch_eff;
   logic [COL_W:0]    col_step;
   logic [ROW_W:0]    row_step;
   logic              put_write;
   logic              need_scroll;
   logic [ADDR_W-1:0] cursor_lin;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              sweep_last;
   logic              read_oor;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff       <= TEXT_COLOR_RESET;
         background_color_ff <= BACKGROUND_COLOR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TEXT_COLOR:       text_color_ff       <= csr_wdata;
            CSR_BACKGROUND_COLOR: background_color_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign is_tab     = (req_ff.character == CH_TAB);
   assign ch_eff     = is_tab ? CH_SPACE : req_ff.character;
   assign cursor_lin = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff);
   assign sweep_last = (sweep_ff == ADDR_W'(CELLS - 1));
   assign read_oor   = (32'(req_ff.read_index) >= 32'(CELLS));

   always_comb begin
      put_write = 1'b0;
      col_step  = {1'b0, col_ff};
      row_step  = {1'b0, row_ff};
      case (ch_eff)
         CH_NEWLINE: begin
            col_step = '0;
            row_step = {1'b0, row_ff} + 1'b1;
         end
         CH_RETURN: begin
            col_step = '0;
         end
         default: begin
            put_write = 1'b1;
            col_step  = {1'b0, col_ff} + 1'b1;
         end
      endcase
      if (col_step >= (COL_W + 1)'(COLUMNS)) begin
         col_step = '0;
         row_step = row_step + 1'b1;
      end
      need_scroll = (row_step >= (ROW_W + 1)'(ROWS));
      col_in      = col_step[COL_W-1:0];
      row_in      = need_scroll ? ROW_W'(ROWS - 1) : row_step[ROW_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= ROW_W'(ROWS - 1);
         puts_ff     <= '0;
         all_done_ff <= 1'b0;
         scrolled_ff <= 1'b0;
         sweep_ff    <= '0;
      end else begin
         if (cmd.capture) begin
            puts_ff     <= '0;
            all_done_ff <= 1'b0;
            scrolled_ff <= 1'b0;
         end
         if (cmd.put) begin
            col_ff  <= col_in;
            row_ff  <= row_in;
            puts_ff <= puts_ff + 1'b1;
            if (status.last_put) begin
               all_done_ff <= 1'b1;
            end
            if (need_scroll) begin
               scrolled_ff <= 1'b1;
            end
         end
         if (cmd.sweep) begin
            sweep_ff <= sweep_last ? '0 : sweep_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
      if (cmd.read) begin
         oor_ff <= read_oor;
      end
   end

   always_comb begin
      rd_en      = 1'b0;
      rd_addr    = ADDR_W'(req_ff.read_index);
      wq_en_in   = 1'b0;
      wq_copy_in = 1'b0;
      wq_addr_in = cursor_lin;
      wq_data_in = {background_color_ff, text_color_ff, ch_eff};
      if (cmd.put) begin
         wq_en_in = put_write;
      end else if (cmd.read) begin
         rd_en = 1'b1;
      end else if (cmd.sweep) begin
         wq_en_in   = 1'b1;
         wq_addr_in = sweep_ff;
         if (cmd.clear) begin
            wq_data_in = '0;
         end else if (sweep_ff < ADDR_W'(CELLS - COLUMNS)) begin
            rd_en      = 1'b1;
            rd_addr    = sweep_ff + ADDR_W'(COLUMNS);
            wq_copy_in = 1'b1;
         end else begin
            wq_data_in = FILL_CELL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wq_en_ff <= 1'b0;
      end else begin
         wq_en_ff <= wq_en_in;
      end
   end

   always_ff @(posedge clock) begin
      wq_copy_ff <= wq_copy_in;
      wq_addr_ff <= wq_addr_in;
      wq_data_ff <= wq_data_in;
   end

   always_ff @(posedge clock) begin
      if (wq_en_ff) begin
         cell_mem_ff[wq_addr_ff] <= wq_copy_ff ? rd_ff : wq_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= cell_mem_ff[rd_addr];
      end
   end

   always_comb begin
      rsp_in.cursor_column = 7'(col_ff);
      rsp_in.cursor_row    = 6'(row_ff);
      rsp_in.cursor_linear = 12'(cursor_lin);
      rsp_in.cell_data     = (req_ff.func == FUNC_READ && !oor_ff) ? rd_ff : '0;
      rsp_in.did_scroll    = scrolled_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      status.req_read      = (req_payload.func == FUNC_READ);
      status.need_scroll   = need_scroll;
      status.last_put      = !is_tab || (puts_ff == 2'd3);
      status.all_puts_done = all_done_ff;
      status.sweep_last    = sweep_last;
      status.rsp_free      = !rsp_valid_ff || rsp_ready;
   end

endmodule

FILE: design/text_console_writer_core.sv
// channel   direction  handshake              payload
// req_      in         req_valid/req_ready    req_payload (func, character, read_index)
// rsp_      out        rsp_valid/rsp_ready    rsp_payload (cursor, cell_data, did_scroll)
// csr_      in         csr_we                 csr_index, csr_wdata
//
// A tab item is written as four spaces. A scroll walks all COLUMNS*ROWS cells
// (4000) of the cell memory one cell per cycle, with one read and one write port.
// After reset a clearing pass over all 4000 cells zeroes the memory before the
// first item is taken. A finished result waits in the output register; the next
// item is taken meanwhile.
module text_console_writer_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tcw_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tcw_pkg::rsp_type rsp_payload,
   input  logic             csr_we,
   input  logic [0:0]       csr_index,
   input  logic [3:0]       csr_wdata
);
   import tcw_pkg::*;

   cmd_type    cmd;
   status_type status;

   tcw_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

FILE: design/tcw_checker.sv
module tcw_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input tcw_pkg::rsp_type rsp_payload
);
   import tcw_pkg::*;

   logic [31:0] lin_expect;

   assign lin_expect = 32'(rsp_payload.cursor_row) * 32'(COLUMNS)
                     + 32'(rsp_payload.cursor_column);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result item dropped or changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while one is in progress");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_payload.cursor_column) < 32'(COLUMNS)
                 && 32'(rsp_payload.cursor_row) < 32'(ROWS))
      else $error("cursor outside the cell grid");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.cursor_linear == 12'(lin_expect))
      else $error("linear cursor position mismatch");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result item shown right after reset");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

FILE: verif/text_console_writer_core_tb.sv
module text_console_writer_core_tb;
   import tcw_pkg::*;

   localparam int CYCLE_LIMIT     = 2_000_000;
   localparam int HOLD_OFF_CYCLES = 600;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;
   logic    csr_we;
   logic [0:0] csr_index;
   logic [3:0] csr_wdata;

   logic [CELL_W-1:0] screen [CELLS];
   int unsigned cur_col;
   int unsigned cur_row;
   logic [3:0] fg_color;
   logic [3:0] bg_color;

   rsp_type replies_due[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   bit idle_on = 1'b1;
   int hold_off_asked = 0;
   int hold_off_done = 0;

   text_console_writer_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // one character at the cursor; returns 1 when the store scrolled
   function automatic bit place_char(input logic [7:0] code);
      bit scrolled;
      scrolled = 1'b0;
      if (code == CH_NEWLINE) begin
         cur_col = 0;
         cur_row++;
      end else if (code == CH_RETURN) begin
         cur_col = 0;
      end else begin
         screen[cur_row * COLUMNS + cur_col] = {bg_color, fg_color, code};
         cur_col++;
      end
      if (cur_col >= COLUMNS) begin
         cur_col = 0;
         cur_row++;
      end
      if (cur_row >= ROWS) begin
         cur_row = ROWS - 1;
         for (int i = 0; i < CELLS - COLUMNS; i++)
            screen[i] = screen[i + COLUMNS];
         for (int i = CELLS - COLUMNS; i < CELLS; i++)
            screen[i] = FILL_CELL;
         scrolled = 1'b1;
      end
      return scrolled;
   endfunction

   function automatic rsp_type expected_console_reply(input req_type item);
      rsp_type r;
      r = '0;
      if (item.func == FUNC_WRITE) begin
         if (item.character == CH_TAB) begin
            for (int k = 0; k < 4; k++)
               if (place_char(CH_SPACE))
                  r.did_scroll = 1'b1;
         end else begin
            r.did_scroll = place_char(item.character);
         end
      end else if (item.read_index < CELLS) begin
         r.cell_data = screen[item.read_index];
      end
      r.cursor_column = 7'(cur_col);
      r.cursor_row = 6'(cur_row);
      r.cursor_linear = 12'(cur_row * COLUMNS + cur_col);
      return r;
   endfunction

   function automatic req_type write_item(input logic [7:0] code);
      req_type item;
      item.func = FUNC_WRITE;
      item.character = code;
      item.read_index = 12'($urandom_range(4095));
      return item;
   endfunction

   function automatic req_type read_item(input logic [11:0] index);
      req_type item;
      item.func = FUNC_READ;
      item.character = 8'($urandom_range(255));
      item.read_index = index;
      return item;
   endfunction

   function automatic logic [7:0] plain_code();
      logic [7:0] c;
      do
         c = 8'($urandom_range(255));
      while (c == CH_TAB || c == CH_NEWLINE || c == CH_RETURN);
      return c;
   endfunction

   function automatic req_type random_console_item();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 30) begin
         if ($urandom_range(3) == 0)
            return read_item(12'($urandom_range(4095)));
         return read_item(12'($urandom_range(CELLS - 1, (ROWS - 10) * COLUMNS)));
      end
      if (pick < 31)
         return write_item(CH_NEWLINE);
      if (pick < 33)
         return write_item(CH_RETURN);
      if (pick < 36)
         return write_item(CH_TAB);
      return write_item(8'($urandom_range(255)));
   endfunction

   function automatic void check_field(input string field_name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field_name, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic send_item(input req_type item);
      while (idle_on && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_payload <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_ready !== 1'b1)
         @(posedge clock);
      replies_due.push_back(expected_console_reply(item));
   endtask

   // drop valid and wait until every reply is back
   task automatic settle_console();
      req_valid <= 1'b0;
      while (replies_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_colors(input logic [3:0] fg, input logic [3:0] bg);
      csr_we <= 1'b1;
      csr_index <= CSR_TEXT_COLOR;
      csr_wdata <= fg;
      @(posedge clock);
      fg_color = fg;
      csr_index <= CSR_BACKGROUND_COLOR;
      csr_wdata <= bg;
      @(posedge clock);
      bg_color = bg;
      csr_we <= 1'b0;
   endtask

   task automatic test_directed_cases();
      send_item(read_item(12'd0));
      send_item(read_item(12'(CELLS - 1)));
      send_item(read_item(12'(CELLS)));
      send_item(read_item(12'hFFF));
      send_item(write_item(8'h41));
      send_item(write_item(8'h00));
      send_item(write_item(8'hFF));
      send_item(read_item(12'((ROWS - 1) * COLUMNS)));
      send_item(read_item(12'((ROWS - 1) * COLUMNS + 2)));
      send_item(write_item(CH_TAB));
      send_item(write_item(CH_RETURN));
      send_item(read_item({4'd0, CH_NEWLINE}));
      send_item(write_item(CH_NEWLINE));
      send_item(read_item(12'(CELLS - 1)));
      send_item(read_item(12'((ROWS - 2) * COLUMNS)));
      send_item(read_item(12'((ROWS - 2) * COLUMNS + 3)));
      send_item(write_item(CH_NEWLINE));
      send_item(read_item(12'((ROWS - 3) * COLUMNS + 1)));
      settle_console();
   endtask

   // fill a line up to the tab so that it wraps and scrolls
   task automatic test_line_wrap();
      for (int end_col = COLUMNS - 4; end_col < COLUMNS; end_col++) begin
         settle_console();
         write_colors(4'($urandom_range(15)), 4'($urandom_range(15)));
         send_item(write_item(CH_RETURN));
         for (int i = 0; i < end_col; i++)
            send_item(write_item(plain_code()));
         send_item(write_item(CH_TAB));
         repeat (3) send_item(read_item(12'((ROWS - 2) * COLUMNS + $urandom_range(COLUMNS - 1))));
         repeat (2) send_item(read_item(12'((ROWS - 1) * COLUMNS + $urandom_range(5))));
      end
      settle_console();
   endtask

   task automatic test_color_settings();
      logic [3:0] fg_list [5];
      logic [3:0] bg_list [5];
      fg_list = '{4'd0, 4'd15, 4'd0, 4'd15, 4'd9};
      bg_list = '{4'd0, 4'd15, 4'd15, 4'd0, 4'd6};
      for (int p = 0; p < 5; p++) begin
         settle_console();
         write_colors(fg_list[p], bg_list[p]);
         repeat (40) send_item(random_console_item());
      end
      settle_console();
   endtask

   // hold the reply side off while items keep coming
   task automatic test_backpressure();
      idle_on = 1'b0;
      hold_off_asked++;
      repeat (20) send_item(write_item(plain_code()));
      repeat (20) send_item(random_console_item());
      idle_on = 1'b1;
      settle_console();
   endtask

   task automatic test_burst();
      idle_on = 1'b0;
      repeat (200) send_item(random_console_item());
      idle_on = 1'b1;
      settle_console();
   endtask

   task automatic test_random_mix();
      for (int chunk = 0; chunk < 4; chunk++) begin
         settle_console();
         write_colors(4'($urandom_range(15)), 4'($urandom_range(15)));
         repeat (290) send_item(random_console_item());
      end
      settle_console();
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_asked != hold_off_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_done++;
         end
         rsp_ready <= !idle_on || $urandom_range(99) >= 29;
      end
   end

   always @(posedge clock) begin : check_reply
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (replies_due.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual %h", $time, rsp_payload);
            mismatch_count++;
         end else begin
            want = replies_due.pop_front();
            check_field("cursor_column", 32'(want.cursor_column),
                        32'(rsp_payload.cursor_column));
            check_field("cursor_row", 32'(want.cursor_row), 32'(rsp_payload.cursor_row));
            check_field("cursor_linear", 32'(want.cursor_linear),
                        32'(rsp_payload.cursor_linear));
            check_field("cell_data", 32'(want.cell_data), 32'(rsp_payload.cell_data));
            check_field("did_scroll", 32'(want.did_scroll), 32'(rsp_payload.did_scroll));
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_index = CSR_TEXT_COLOR;
      csr_wdata = '0;
      foreach (screen[i])
         screen[i] = '0;
      cur_col = 0;
      cur_row = ROWS - 1;
      fg_color = TEXT_COLOR_RESET;
      bg_color = BACKGROUND_COLOR_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_line_wrap();
      test_color_settings();
      test_backpressure();
      test_burst();
      test_random_mix();
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
